/* src/shp_pkg.sv */
// Shared types, constants and lookup tables for the TLS 1.3 ServerHello parser.
// Used by shp_parser, tls13_server_hello_parser, shp_hello_checker and tb_top; depends on nothing else.
package shp_pkg;

    // Default upper bound on accepted record body bytes
    localparam int BODY_MAX_DEF = 32768;

    // Fixed field widths
    localparam int SUITE_W = 16;
    localparam int KEY_W   = 15;
    localparam int MLEN_W  = 24;
    localparam int EXT_W   = 17;

    // Protocol constants
    localparam logic [7:0]  HANDSHAKE_TYPE   = 8'd22;
    localparam logic [7:0]  SERVER_HELLO     = 8'd2;
    localparam logic [15:0] EXT_KEY_SHARE    = 16'd51;
    localparam logic [15:0] GROUP_X25519     = 16'h001d;
    localparam logic [15:0] X25519_KEY_LEN   = 16'd32;
    localparam logic [15:0] SUITE_AES128_GCM = 16'h1301;
    localparam logic [15:0] SUITE_CHACHA20   = 16'h1303;
    localparam int          MIN_BODY_LEN     = 44;
    localparam int          MIN_MSG_LEN      = 40;

    // Fixed header byte positions
    localparam int POS_MLEN_LAST    = 3;
    localparam int POS_RANDOM_FIRST = 6;
    localparam int POS_SENTINEL     = 30;
    localparam int POS_RANDOM_LAST  = 37;
    localparam int POS_SID_LEN      = 38;
    localparam int POS_FIXED_END    = 39;

    // HelloRetryRequest special random value
    localparam logic [7:0] RETRY_RANDOM [32] = '{
        8'hCF, 8'h21, 8'hAD, 8'h74, 8'hE5, 8'h9A, 8'h61, 8'h11,
        8'hBE, 8'h1D, 8'h8C, 8'h02, 8'h1E, 8'h65, 8'hB8, 8'h91,
        8'hC2, 8'hA2, 8'h11, 8'h16, 8'h7A, 8'hBB, 8'h8C, 8'h5E,
        8'h07, 8'h9E, 8'h09, 8'hE2, 8'hC8, 8'hA8, 8'h33, 8'h9C
    };

    // Downgrade sentinels in the last 8 random bytes (TLS 1.2 and TLS 1.1)
    localparam logic [7:0] SENTINEL12 [8] = '{
        8'h44, 8'h4F, 8'h57, 8'h4E, 8'h47, 8'h52, 8'h44, 8'h01
    };
    localparam logic [7:0] SENTINEL11 [8] = '{
        8'h44, 8'h4F, 8'h57, 8'h4E, 8'h47, 8'h52, 8'h44, 8'h00
    };

    // Result status codes, in priority order after the overlong check
    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_NOT_SH      = 4'd1,
        ST_BAD_LEN     = 4'd2,
        ST_RETRY       = 4'd3,
        ST_DOWNGRADE   = 4'd4,
        ST_TRUNCATED   = 4'd5,
        ST_EXT_OVERRUN = 4'd6,
        ST_NO_KEY      = 4'd7,
        ST_BAD_SUITE   = 4'd8
    } status_t;

    // Parse phase
    typedef enum logic [1:0] {
        PH_FIXED,
        PH_SUITE,
        PH_EXT,
        PH_DONE
    } phase_t;

    // One result; status lands in the lowest bits when packed
    typedef struct packed {
        logic [KEY_W-1:0]   key_offset;
        logic [SUITE_W-1:0] cipher_suite;
        status_t            status;
    } result_t;

    localparam int RESULT_W    = $bits(result_t);
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

/* src/shp_parser.sv */
// Per-byte ServerHello parse state and final status logic.
// Depends on shp_pkg.
module shp_parser #(
    parameter int BODY_MAX = shp_pkg::BODY_MAX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic [7:0]        record_type,
    input  logic              last_byte,
    output shp_pkg::result_t  res
);

    localparam int POS_W  = $clog2(BODY_MAX + 1);
    localparam int NFP_W  = (POS_W > 9) ? POS_W : 9;
    localparam int WIDE_W = 26;

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(BODY_MAX);

    // State registers
    logic [POS_W-1:0]            pos_reg,    pos_next;
    logic [shp_pkg::MLEN_W-1:0]  mlen_reg,   mlen_next;
    logic [NFP_W-1:0]            nfp_reg,    nfp_next;
    logic [shp_pkg::EXT_W-1:0]   ext_end_reg, ext_end_next;
    logic [31:0]                 hdr_reg,    hdr_next;
    logic [23:0]                 gkl_reg,    gkl_next;
    logic                        retry_reg,  retry_next;
    logic [1:0]                  dg_reg,     dg_next;
    logic [shp_pkg::SUITE_W-1:0] suite_reg,  suite_next;
    logic [shp_pkg::KEY_W-1:0]   koff_reg,   koff_next;
    logic                        kfound_reg, kfound_next;
    shp_pkg::status_t            err_reg,    err_next;
    logic                        long_reg,   long_next;
    shp_pkg::phase_t             phase_reg,  phase_next;

    // Working values
    logic [POS_W-1:0]  pos_inc;
    logic [POS_W-1:0]  ofs6;
    logic [WIDE_W-1:0] pos_w, nfp_w, d_w, msg_end_w, ext_new_w;
    logic [31:0]       hdr_now;
    logic [15:0]       ext_len;
    logic              retry_now;
    logic [1:0]        dg_now;
    shp_pkg::status_t  st;

    // Phase register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= shp_pkg::PH_FIXED;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // Remaining parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            mlen_reg    <= '0;
            nfp_reg     <= '0;
            ext_end_reg <= '0;
            hdr_reg     <= '0;
            gkl_reg     <= '0;
            retry_reg   <= 1'b1;
            dg_reg      <= 2'b11;
            suite_reg   <= '0;
            koff_reg    <= '0;
            kfound_reg  <= 1'b0;
            err_reg     <= shp_pkg::ST_OK;
            long_reg    <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            mlen_reg    <= mlen_next;
            nfp_reg     <= nfp_next;
            ext_end_reg <= ext_end_next;
            hdr_reg     <= hdr_next;
            gkl_reg     <= gkl_next;
            retry_reg   <= retry_next;
            dg_reg      <= dg_next;
            suite_reg   <= suite_next;
            koff_reg    <= koff_next;
            kfound_reg  <= kfound_next;
            err_reg     <= err_next;
            long_reg    <= long_next;
        end
    end

    // Next state for one byte, final status on the last byte
    always_comb
    begin
        pos_next     = pos_reg;
        mlen_next    = mlen_reg;
        nfp_next     = nfp_reg;
        ext_end_next = ext_end_reg;
        hdr_next     = hdr_reg;
        gkl_next     = gkl_reg;
        retry_next   = retry_reg;
        dg_next      = dg_reg;
        suite_next   = suite_reg;
        koff_next    = koff_reg;
        kfound_next  = kfound_reg;
        err_next     = err_reg;
        long_next    = long_reg;
        phase_next   = phase_reg;

        pos_inc   = pos_reg + 1'b1;
        ofs6      = pos_reg - POS_W'(shp_pkg::POS_RANDOM_FIRST);
        pos_w     = WIDE_W'(pos_reg);
        nfp_w     = WIDE_W'(nfp_reg);
        d_w       = pos_w - nfp_w;
        msg_end_w = WIDE_W'(mlen_reg) + WIDE_W'(4);
        hdr_now   = hdr_reg;
        ext_len   = {ext_end_reg[7:0], data_byte};
        ext_new_w = nfp_w + WIDE_W'(5) + WIDE_W'(ext_len);
        retry_now = retry_reg & (data_byte == shp_pkg::RETRY_RANDOM[ofs6[4:0]]);
        dg_now    = dg_reg;
        if (pos_reg >= POS_W'(shp_pkg::POS_SENTINEL))
        begin
            dg_now[0] = dg_reg[0] & (data_byte == shp_pkg::SENTINEL12[ofs6[2:0]]);
            dg_now[1] = dg_reg[1] & (data_byte == shp_pkg::SENTINEL11[ofs6[2:0]]);
        end

        if (step)
        begin
            if (pos_reg == POS_LIMIT)
            begin
                // overlong body: ignore the byte, position stays saturated
                long_next = 1'b1;
            end
            else
            begin
                pos_next = pos_inc;
                if (pos_reg < POS_W'(shp_pkg::POS_FIXED_END))
                begin
                    // fixed header section
                    if (pos_reg == '0)
                    begin
                        if (record_type != shp_pkg::HANDSHAKE_TYPE ||
                            data_byte != shp_pkg::SERVER_HELLO)
                        begin
                            err_next = shp_pkg::ST_NOT_SH;
                        end
                    end
                    else if (pos_reg <= POS_W'(shp_pkg::POS_MLEN_LAST))
                    begin
                        mlen_next = {mlen_reg[15:0], data_byte};
                    end
                    else if (pos_reg >= POS_W'(shp_pkg::POS_RANDOM_FIRST) &&
                             pos_reg <= POS_W'(shp_pkg::POS_RANDOM_LAST))
                    begin
                        retry_next = retry_now;
                        dg_next    = dg_now;
                        if (pos_reg == POS_W'(shp_pkg::POS_RANDOM_LAST) &&
                            err_reg == shp_pkg::ST_OK)
                        begin
                            if (retry_now)
                            begin
                                err_next = shp_pkg::ST_RETRY;
                            end
                            else if (dg_now != 2'b00)
                            begin
                                err_next = shp_pkg::ST_DOWNGRADE;
                            end
                        end
                    end
                    else if (pos_reg == POS_W'(shp_pkg::POS_SID_LEN))
                    begin
                        // skip the session id
                        nfp_next = NFP_W'(shp_pkg::POS_FIXED_END) + NFP_W'(data_byte);
                        if (WIDE_W'(nfp_next) + WIDE_W'(5) > msg_end_w)
                        begin
                            if (err_reg == shp_pkg::ST_OK)
                            begin
                                err_next = shp_pkg::ST_TRUNCATED;
                            end
                            phase_next = shp_pkg::PH_DONE;
                        end
                        else
                        begin
                            phase_next = shp_pkg::PH_SUITE;
                        end
                    end
                end
                else if (pos_w >= nfp_w)
                begin
                    case (phase_reg)
                        shp_pkg::PH_SUITE:
                        begin
                            // suite, compression, extensions length
                            if (d_w <= WIDE_W'(1))
                            begin
                                suite_next = {suite_reg[7:0], data_byte};
                            end
                            else if (d_w == WIDE_W'(3))
                            begin
                                ext_end_next = shp_pkg::EXT_W'(data_byte);
                            end
                            else if (d_w == WIDE_W'(4))
                            begin
                                ext_end_next = shp_pkg::EXT_W'(ext_new_w);
                                if (ext_new_w > msg_end_w && err_reg == shp_pkg::ST_OK)
                                begin
                                    err_next = shp_pkg::ST_EXT_OVERRUN;
                                end
                                nfp_next = NFP_W'(pos_inc);
                                hdr_next = '0;
                                gkl_next = '0;
                                phase_next = (WIDE_W'(pos_inc) + WIDE_W'(4) >
                                              WIDE_W'(shp_pkg::EXT_W'(ext_new_w)))
                                             ? shp_pkg::PH_DONE : shp_pkg::PH_EXT;
                            end
                        end
                        shp_pkg::PH_EXT:
                        begin
                            // extension walk
                            if (d_w < WIDE_W'(4))
                            begin
                                hdr_now  = {hdr_reg[23:0], data_byte};
                                hdr_next = hdr_now;
                            end
                            if (d_w == WIDE_W'(3) &&
                                nfp_w + WIDE_W'(4) + WIDE_W'(hdr_now[15:0]) >
                                WIDE_W'(ext_end_reg))
                            begin
                                phase_next = shp_pkg::PH_DONE;
                            end
                            else
                            begin
                                if (d_w >= WIDE_W'(4) && d_w <= WIDE_W'(7) &&
                                    hdr_now[31:16] == shp_pkg::EXT_KEY_SHARE &&
                                    hdr_now[15:0] >= 16'd4)
                                begin
                                    gkl_next = {gkl_reg[15:0], data_byte};
                                    if (d_w == WIDE_W'(7) &&
                                        gkl_reg[23:8] == shp_pkg::GROUP_X25519 &&
                                        {gkl_reg[7:0], data_byte} == shp_pkg::X25519_KEY_LEN &&
                                        hdr_now[15:0] >= 16'd36)
                                    begin
                                        koff_next   = shp_pkg::KEY_W'(nfp_w + WIDE_W'(8));
                                        kfound_next = 1'b1;
                                    end
                                end
                                if (d_w >= WIDE_W'(3) &&
                                    d_w == WIDE_W'(3) + WIDE_W'(hdr_now[15:0]))
                                begin
                                    nfp_next = NFP_W'(pos_inc);
                                    hdr_next = '0;
                                    gkl_next = '0;
                                    phase_next = (WIDE_W'(pos_inc) + WIDE_W'(4) >
                                                  WIDE_W'(ext_end_reg))
                                                 ? shp_pkg::PH_DONE : shp_pkg::PH_EXT;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
        end

        // Final status from the updated state
        if (long_next)
        begin
            st = shp_pkg::ST_BAD_LEN;
        end
        else if (err_next == shp_pkg::ST_NOT_SH)
        begin
            st = shp_pkg::ST_NOT_SH;
        end
        else if (pos_next < POS_W'(shp_pkg::MIN_BODY_LEN) ||
                 mlen_next < shp_pkg::MLEN_W'(shp_pkg::MIN_MSG_LEN) ||
                 WIDE_W'(mlen_next) + WIDE_W'(4) > WIDE_W'(pos_next))
        begin
            st = shp_pkg::ST_BAD_LEN;
        end
        else if (err_next != shp_pkg::ST_OK)
        begin
            st = err_next;
        end
        else if (!kfound_next)
        begin
            st = shp_pkg::ST_NO_KEY;
        end
        else if (suite_next != shp_pkg::SUITE_AES128_GCM &&
                 suite_next != shp_pkg::SUITE_CHACHA20)
        begin
            st = shp_pkg::ST_BAD_SUITE;
        end
        else
        begin
            st = shp_pkg::ST_OK;
        end

        res.status       = st;
        res.cipher_suite = (st == shp_pkg::ST_OK || st == shp_pkg::ST_NO_KEY ||
                            st == shp_pkg::ST_BAD_SUITE) ? suite_next : '0;
        res.key_offset   = (st == shp_pkg::ST_OK) ? koff_next : '0;

        // Record done: back to the reset state
        if (step && last_byte)
        begin
            pos_next     = '0;
            mlen_next    = '0;
            nfp_next     = '0;
            ext_end_next = '0;
            hdr_next     = '0;
            gkl_next     = '0;
            retry_next   = 1'b1;
            dg_next      = 2'b11;
            suite_next   = '0;
            koff_next    = '0;
            kfound_next  = 1'b0;
            err_next     = shp_pkg::ST_OK;
            long_next    = 1'b0;
            phase_next   = shp_pkg::PH_FIXED;
        end
    end

endmodule

/* src/tls13_server_hello_parser.sv */
// The last body byte's result reaches m_tdata through the input register and then the result register.
// Throughput: one body byte per cycle; each byte is registered and then parsed by one
// pass of compare and counter logic, so the input register frees every cycle.
// A pending result in the output register stalls only a last byte, not the others.
// Reset (rst_n low, asynchronous) clears all control state; the parser waits for byte 0.
// Top level of the TLS 1.3 ServerHello parser: input register and result register.
// Depends on shp_pkg and shp_parser.
module tls13_server_hello_parser #(
    parameter int BODY_MAX = shp_pkg::BODY_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] data_byte
    input  logic [7:0]                      s_tuser,   // [7:0] record_type
    input  logic                            s_tlast,   // last_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [shp_pkg::OUT_TDATA_W-1:0] m_tdata    // [3:0] status,
                                                       // [19:4] cipher_suite,
                                                       // [34:20] key_offset, rest zero
);

    logic                            in_valid_reg, in_valid_next;
    logic [7:0]                      in_data_reg;
    logic [7:0]                      in_type_reg;
    logic                            in_last_reg;
    logic                            out_valid_reg, out_valid_next;
    logic [shp_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic                            out_free;
    logic                            step;
    shp_pkg::result_t                res;

    // Handshake: a last byte waits until the result register can take it
    assign out_free       = !out_valid_reg || m_tready;
    assign step           = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready       = !in_valid_reg || step;
    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = (step && in_last_reg) ? 1'b1
                          : (m_tready ? 1'b0 : out_valid_reg);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
            in_type_reg <= s_tuser;
            in_last_reg <= s_tlast;
        end
    end

    // Parser
    shp_parser #(
        .BODY_MAX (BODY_MAX)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_byte   (in_data_reg),
        .record_type (in_type_reg),
        .last_byte   (in_last_reg),
        .res         (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && in_last_reg)
        begin
            out_data_reg <= {{(shp_pkg::OUT_TDATA_W - shp_pkg::RESULT_W){1'b0}}, res};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* bench/shp_hello_checker.sv */
// Result checker for the TLS 1.3 ServerHello parser: watches both stream channels,
// predicts the verdict of every record from the accepted body bytes and compares.
// Depends on shp_pkg for the status codes, result layout and protocol constants.
module shp_hello_checker #(
    parameter int BODY_MAX = shp_pkg::BODY_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,     // [7:0] data_byte
    input  logic [7:0]                      s_tuser,     // [7:0] record_type
    input  logic                            s_tlast,     // last_byte
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [shp_pkg::OUT_TDATA_W-1:0] m_tdata,     // [3:0] status,
                                                         // [19:4] cipher_suite,
                                                         // [34:20] key_offset, rest zero
    output int                              fails,
    output int                              pending,
    output int                              verdicts_checked,
    output logic [8:0]                      statuses_seen
);

    // Parser state as the predictor sees it
    logic [16:0]               body_pos;
    logic [23:0]               msg_len;
    logic [16:0]               field_pos;
    logic [16:0]               ext_end;
    logic [31:0]               ext_hdr;
    logic [31:0]               share_hdr;
    logic                      retry_seen;
    logic [1:0]                dg_seen;       // bit0 TLS 1.2 sentinel, bit1 TLS 1.1 sentinel
    logic [15:0]               suite_seen;
    logic [shp_pkg::KEY_W-1:0] key_at;
    logic                      key_ok;
    shp_pkg::status_t          first_err;
    shp_pkg::phase_t           parse_ph;
    logic                      body_overflow;

    // Verdicts waiting for the block to report them
    shp_pkg::result_t verdict_q[$];

    task automatic clear_hello_state();
        body_pos      = '0;
        msg_len       = '0;
        field_pos     = '0;
        ext_end       = '0;
        ext_hdr       = '0;
        share_hdr     = '0;
        retry_seen    = 1'b1;
        dg_seen       = 2'b11;
        suite_seen    = '0;
        key_at        = '0;
        key_ok        = 1'b0;
        first_err     = shp_pkg::ST_OK;
        parse_ph      = shp_pkg::PH_FIXED;
        body_overflow = 1'b0;
    endtask

    // Only the first error sticks
    task automatic note_error(input shp_pkg::status_t code);
        if (first_err == shp_pkg::ST_OK)
            first_err = code;
    endtask

    task automatic begin_ext_walk(input int unsigned hdr_pos);
        field_pos = 17'(hdr_pos);
        ext_hdr   = '0;
        share_hdr = '0;
        parse_ph  = (hdr_pos + 4 > ext_end) ? shp_pkg::PH_DONE : shp_pkg::PH_EXT;
    endtask

    // One body byte at position pos
    task automatic hello_parse_byte(input int unsigned pos, input logic [7:0] b,
                                    input logic [7:0] rt);
        int unsigned d;
        int unsigned et;
        int unsigned el;
        int unsigned elen;
        if (pos < shp_pkg::POS_FIXED_END) begin
            if (pos == 0) begin
                if (rt != shp_pkg::HANDSHAKE_TYPE || b != shp_pkg::SERVER_HELLO)
                    note_error(shp_pkg::ST_NOT_SH);
            end else if (pos <= shp_pkg::POS_MLEN_LAST) begin
                msg_len = {msg_len[15:0], b};
            end else if (pos >= shp_pkg::POS_RANDOM_FIRST &&
                         pos <= shp_pkg::POS_RANDOM_LAST) begin
                if (b != shp_pkg::RETRY_RANDOM[pos - shp_pkg::POS_RANDOM_FIRST])
                    retry_seen = 1'b0;
                if (pos >= shp_pkg::POS_SENTINEL) begin
                    if (b != shp_pkg::SENTINEL12[pos - shp_pkg::POS_SENTINEL])
                        dg_seen[0] = 1'b0;
                    if (b != shp_pkg::SENTINEL11[pos - shp_pkg::POS_SENTINEL])
                        dg_seen[1] = 1'b0;
                end
                if (pos == shp_pkg::POS_RANDOM_LAST) begin
                    if (retry_seen)
                        note_error(shp_pkg::ST_RETRY);
                    else if (dg_seen != 2'b00)
                        note_error(shp_pkg::ST_DOWNGRADE);
                end
            end else if (pos == shp_pkg::POS_SID_LEN) begin
                field_pos = 17'(shp_pkg::POS_FIXED_END + int'(b));
                if (field_pos + 5 > msg_len + 4) begin
                    note_error(shp_pkg::ST_TRUNCATED);
                    parse_ph = shp_pkg::PH_DONE;
                end else begin
                    parse_ph = shp_pkg::PH_SUITE;
                end
            end
        end else if (parse_ph == shp_pkg::PH_SUITE && pos >= field_pos) begin
            // suite, compression, extensions length
            d = pos - field_pos;
            if (d <= 1) begin
                suite_seen = {suite_seen[7:0], b};
            end else if (d == 3) begin
                ext_end = 17'(b);
            end else if (d == 4) begin
                elen    = {16'd0, ext_end[7:0], b};
                ext_end = 17'(field_pos + 5 + elen);
                if (ext_end > msg_len + 4)
                    note_error(shp_pkg::ST_EXT_OVERRUN);
                begin_ext_walk(pos + 1);
            end
        end else if (parse_ph == shp_pkg::PH_EXT && pos >= field_pos) begin
            // extension walk
            d = pos - field_pos;
            if (d < 4)
                ext_hdr = {ext_hdr[23:0], b};
            et = {16'd0, ext_hdr[31:16]};
            el = {16'd0, ext_hdr[15:0]};
            if (d == 3 && field_pos + 4 + el > ext_end) begin
                // extension does not fit: the walk ends here
                parse_ph = shp_pkg::PH_DONE;
            end else begin
                if (d >= 4 && d <= 7 && et == shp_pkg::EXT_KEY_SHARE && el >= 4) begin
                    share_hdr = {share_hdr[23:0], b};
                    if (d == 7 && share_hdr[31:16] == shp_pkg::GROUP_X25519 &&
                        share_hdr[15:0] == shp_pkg::X25519_KEY_LEN && el >= 36) begin
                        key_at = shp_pkg::KEY_W'(field_pos + 8);
                        key_ok = 1'b1;
                    end
                end
                if (d >= 3 && d == 3 + el)
                    begin_ext_walk(pos + 1);
            end
        end
    endtask

    // Verdict of the record on its last byte
    function automatic shp_pkg::result_t hello_verdict();
        shp_pkg::result_t r;
        shp_pkg::status_t st;
        int unsigned      shend;
        shend = msg_len + 4;
        if (body_overflow)
            st = shp_pkg::ST_BAD_LEN;
        else if (first_err == shp_pkg::ST_NOT_SH)
            st = shp_pkg::ST_NOT_SH;
        else if (body_pos < shp_pkg::MIN_BODY_LEN || msg_len < shp_pkg::MIN_MSG_LEN ||
                 shend > body_pos)
            st = shp_pkg::ST_BAD_LEN;
        else if (first_err != shp_pkg::ST_OK)
            st = first_err;
        else if (!key_ok)
            st = shp_pkg::ST_NO_KEY;
        else if (suite_seen != shp_pkg::SUITE_AES128_GCM &&
                 suite_seen != shp_pkg::SUITE_CHACHA20)
            st = shp_pkg::ST_BAD_SUITE;
        else
            st = shp_pkg::ST_OK;
        r.status       = st;
        r.cipher_suite = (st == shp_pkg::ST_OK || st == shp_pkg::ST_NO_KEY ||
                          st == shp_pkg::ST_BAD_SUITE) ? suite_seen : '0;
        r.key_offset   = (st == shp_pkg::ST_OK) ? key_at : '0;
        return r;
    endfunction

    // Predict on accepted body bytes, compare on accepted results
    always @(posedge clk or negedge rst_n)
    begin
        shp_pkg::result_t exp_r;
        shp_pkg::result_t got_r;
        int               errs;
        errs = 0;
        if (!rst_n)
        begin
            clear_hello_state();
            verdict_q.delete();
            fails            <= 0;
            pending          <= 0;
            verdicts_checked <= 0;
            statuses_seen    <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (body_pos >= BODY_MAX)
                    body_overflow = 1'b1;
                else
                begin
                    hello_parse_byte(body_pos, s_tdata, s_tuser);
                    body_pos = 17'(body_pos + 1);
                end
                if (s_tlast)
                begin
                    verdict_q.push_back(hello_verdict());
                    clear_hello_state();
                end
            end
            if (m_tvalid && m_tready)
            begin
                got_r = m_tdata[shp_pkg::RESULT_W-1:0];
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected: status %0d suite %h key %0d",
                             $time, got_r.status, got_r.cipher_suite, got_r.key_offset);
                    errs = errs + 1;
                end
                else
                begin
                    exp_r = verdict_q.pop_front();
                    if (got_r.status !== exp_r.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, exp_r.status, got_r.status);
                        errs = errs + 1;
                    end
                    if (got_r.cipher_suite !== exp_r.cipher_suite)
                    begin
                        $display("%0t: cipher_suite expected %h, got %h",
                                 $time, exp_r.cipher_suite, got_r.cipher_suite);
                        errs = errs + 1;
                    end
                    if (got_r.key_offset !== exp_r.key_offset)
                    begin
                        $display("%0t: key_offset expected %0d, got %0d",
                                 $time, exp_r.key_offset, got_r.key_offset);
                        errs = errs + 1;
                    end
                    if (m_tdata[shp_pkg::OUT_TDATA_W-1:shp_pkg::RESULT_W] !== '0)
                    begin
                        $display("%0t: tdata padding expected 0, got %h",
                                 $time, m_tdata[shp_pkg::OUT_TDATA_W-1:shp_pkg::RESULT_W]);
                        errs = errs + 1;
                    end
                    verdicts_checked <= verdicts_checked + 1;
                    statuses_seen[exp_r.status] <= 1'b1;
                end
            end
            fails   <= fails + errs;
            pending <= verdict_q.size();
        end
    end

endmodule

/* bench/tb_top.sv */
// Testbench top for the TLS 1.3 ServerHello parser: clock, reset, record stimulus
// with bursty requests and a stalling receiver, and the final verdict.
// Depends on shp_pkg, tls13_server_hello_parser and shp_hello_checker.
module tb_top;

    localparam int BODY_MAX      = shp_pkg::BODY_MAX_DEF;
    localparam int TOTAL_BYTES   = 1650;
    localparam int RANDOM_RECS   = 4;
    localparam int HOLD_CYCLES   = 400;

    typedef enum int {
        RND_PLAIN,
        RND_RETRY,
        RND_RETRY_NEAR,
        RND_DG12,
        RND_DG11,
        RND_DG_NEAR
    } random_kind_t;

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata  = '0;
    logic [7:0]                      s_tuser  = '0;
    logic                            s_tlast  = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [shp_pkg::OUT_TDATA_W-1:0] m_tdata;

    int         fails;
    int         pending;
    int         verdicts_checked;
    logic [8:0] statuses_seen;

    // Record under construction
    logic [7:0] body_q[$];
    logic [7:0] ext_q[$];
    logic [7:0] rec_type;
    int         records_sent;
    int         bytes_sent;
    int         burst_left;
    bit         hold_wanted;
    bit         hold_done;

    tls13_server_hello_parser #(
        .BODY_MAX (BODY_MAX)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    shp_hello_checker #(
        .BODY_MAX (BODY_MAX)
    ) u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .fails            (fails),
        .pending          (pending),
        .verdicts_checked (verdicts_checked),
        .statuses_seen    (statuses_seen)
    );

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

    // One body byte as a request; gaps between bursts
    task automatic push_byte(input logic [7:0] b, input logic [7:0] rt, input logic lst);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tuser  <= 8'($urandom);
            s_tlast  <= 1'($urandom);
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                     : $urandom_range(1, 24);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= rt;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left = burst_left - 1;
        bytes_sent = bytes_sent + 1;
    endtask

    // Record type on the first byte only; other bytes carry noise there
    task automatic send_record();
        int i;
        for (i = 0; i < body_q.size(); i++)
            push_byte(body_q[i], (i == 0) ? rec_type : 8'($urandom), i == body_q.size() - 1);
        records_sent = records_sent + 1;
    endtask

    task automatic put_ext(input logic [15:0] et, input int el);
        ext_q.push_back(et[15:8]);
        ext_q.push_back(et[7:0]);
        ext_q.push_back(8'(el >> 8));
        ext_q.push_back(8'(el));
        repeat (el) ext_q.push_back(8'($urandom));
    endtask

    task automatic put_key_share(input logic [15:0] grp, input logic [15:0] klen, input int el);
        ext_q.push_back(shp_pkg::EXT_KEY_SHARE[15:8]);
        ext_q.push_back(shp_pkg::EXT_KEY_SHARE[7:0]);
        ext_q.push_back(8'(el >> 8));
        ext_q.push_back(8'(el));
        if (el >= 4)
        begin
            ext_q.push_back(grp[15:8]);
            ext_q.push_back(grp[7:0]);
            ext_q.push_back(klen[15:8]);
            ext_q.push_back(klen[7:0]);
            repeat (el - 4) ext_q.push_back(8'($urandom));
        end
        else
        begin
            repeat (el) ext_q.push_back(8'($urandom));
        end
    endtask

    // Well-formed ServerHello around the extensions in ext_q
    task automatic build_hello(input random_kind_t kind, input int sid_len,
                               input logic [15:0] suite);
        int          i;
        int          j;
        logic [7:0]  rnd [32];
        logic [23:0] mlen;
        logic [15:0] elen;
        body_q.delete();
        body_q.push_back(shp_pkg::SERVER_HELLO);
        repeat (3) body_q.push_back(8'h00);
        body_q.push_back(8'h03);
        body_q.push_back(8'h03);
        for (i = 0; i < 32; i++)
            rnd[i] = 8'($urandom);
        for (i = 0; i < 32; i++)
            if (kind == RND_RETRY || kind == RND_RETRY_NEAR)
                rnd[i] = shp_pkg::RETRY_RANDOM[i];
        for (i = 0; i < 8; i++)
        begin
            if (kind == RND_DG12 || kind == RND_DG_NEAR)
                rnd[24 + i] = shp_pkg::SENTINEL12[i];
            else if (kind == RND_DG11)
                rnd[24 + i] = shp_pkg::SENTINEL11[i];
        end
        if (kind == RND_RETRY_NEAR)
        begin
            j = $urandom_range(0, 31);
            rnd[j] ^= 8'($urandom_range(1, 255));
        end
        if (kind == RND_DG_NEAR)
        begin
            j = $urandom_range(24, 31);
            rnd[j] ^= 8'($urandom_range(1, 255));
        end
        for (i = 0; i < 32; i++)
            body_q.push_back(rnd[i]);
        body_q.push_back(8'(sid_len));
        repeat (sid_len) body_q.push_back(8'($urandom));
        body_q.push_back(suite[15:8]);
        body_q.push_back(suite[7:0]);
        body_q.push_back(8'h00);
        elen = 16'(ext_q.size());
        body_q.push_back(elen[15:8]);
        body_q.push_back(elen[7:0]);
        foreach (ext_q[k])
            body_q.push_back(ext_q[k]);
        ext_q.delete();
        mlen = 24'(body_q.size() - 4);
        body_q[1] = mlen[23:16];
        body_q[2] = mlen[15:8];
        body_q[3] = mlen[7:0];
        rec_type = shp_pkg::HANDSHAKE_TYPE;
    endtask

    // Breaks one thing in a built hello
    task automatic mutate_hello(input int sid_len);
        int n;
        case ($urandom_range(0, 7))
            0: body_q[3] ^= 8'($urandom_range(1, 255));
            1: body_q[43 + sid_len] ^= 8'($urandom_range(1, 255));
            2:
            begin
                n = $urandom_range(1, 12);
                repeat (n)
                    if (body_q.size() > 1)
                        void'(body_q.pop_back());
            end
            3: repeat ($urandom_range(1, 8)) body_q.push_back(8'($urandom));
            4:
            begin
                n = $urandom_range(0, body_q.size() - 1);
                body_q[n] ^= 8'($urandom_range(1, 255));
            end
            5: body_q[0] = 8'($urandom);
            6: body_q[38] = 8'($urandom);
            default: rec_type = 8'($urandom);
        endcase
    endtask

    task automatic random_extensions();
        int n;
        n = $urandom_range(0, 4);
        repeat (n)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: put_key_share(shp_pkg::GROUP_X25519, shp_pkg::X25519_KEY_LEN, 36);
                4, 5:       put_ext(16'd43, 2);
                6:          put_ext(16'($urandom), $urandom_range(0, 12));
                7:          put_key_share(($urandom_range(0, 1) == 0) ? shp_pkg::GROUP_X25519
                                                                      : 16'($urandom),
                                          ($urandom_range(0, 1) == 0) ? shp_pkg::X25519_KEY_LEN
                                                                      : 16'($urandom),
                                          $urandom_range(0, 40));
                8:          put_key_share(shp_pkg::GROUP_X25519, shp_pkg::X25519_KEY_LEN,
                                          $urandom_range(36, 44));
                default:    put_ext(shp_pkg::EXT_KEY_SHARE, $urandom_range(0, 3));
            endcase
        end
    endtask

    task automatic noise_record(input int max_len);
        int n;
        n = $urandom_range(1, max_len);
        body_q.delete();
        repeat (n) body_q.push_back(8'($urandom));
        if ($urandom_range(0, 1) == 0)
            body_q[0] = shp_pkg::SERVER_HELLO;
        rec_type = ($urandom_range(0, 4) == 0) ? 8'($urandom) : shp_pkg::HANDSHAKE_TYPE;
    endtask

    // Receiver: changing stall patterns, one long hold-off on request
    initial
    begin
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_wanted && !hold_done)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left = mode_left - 1;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ~m_tready;
                endcase
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int           sid;
        int           start_recs;
        int           pick;
        logic [15:0]  suite;
        random_kind_t kind;
        records_sent = 0;
        bytes_sent   = 0;
        burst_left   = 0;
        hold_wanted  = 1'b0;
        rec_type     = shp_pkg::HANDSHAKE_TYPE;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed records
        put_ext(16'd43, 2);
        put_key_share(shp_pkg::GROUP_X25519, shp_pkg::X25519_KEY_LEN, 36);
        build_hello(RND_PLAIN, 0, shp_pkg::SUITE_AES128_GCM);
        send_record();
        put_key_share(shp_pkg::GROUP_X25519, shp_pkg::X25519_KEY_LEN, 36);
        build_hello(RND_PLAIN, 32, shp_pkg::SUITE_CHACHA20);
        send_record();
        // unsupported suite
        put_key_share(shp_pkg::GROUP_X25519, shp_pkg::X25519_KEY_LEN, 36);
        build_hello(RND_PLAIN, 0, 16'hFFFF);
        send_record();
        // no key share at all
        put_ext(16'd43, 2);
        build_hello(RND_PLAIN, 5, shp_pkg::SUITE_AES128_GCM);
        send_record();
        // key share with the wrong group, wrong key length, too short
        put_key_share(16'h0017, shp_pkg::X25519_KEY_LEN, 36);
        build_hello(RND_PLAIN, 0, shp_pkg::SUITE_AES128_GCM);
        send_record();
        put_key_share(shp_pkg::GROUP_X25519, 16'd31, 36);
        build_hello(RND_PLAIN, 0, shp_pkg::SUITE_AES128_GCM);
        send_record();
        put_key_share(shp_pkg::GROUP_X25519, shp_pkg::X25519_KEY_LEN, 4);
        build_hello(RND_PLAIN, 0, shp_pkg::SUITE_AES128_GCM);
        send_record();
        // two key shares: the later one counts
        put_key_share(shp_pkg::GROUP_X25519, shp_pkg::X25519_KEY_LEN, 36);
        put_ext(16'd0, 0);
        put_key_share(shp_pkg::GROUP_X25519, shp_pkg::X25519_KEY_LEN, 36);
        build_hello(RND_PLAIN, 3, shp_pkg::SUITE_CHACHA20);
        send_record();
        // not a ServerHello: wrong message type, then wrong record type
        put_key_share(shp_pkg::GROUP_X25519, shp_pkg::X25519_KEY_LEN, 36);
        build_hello(RND_PLAIN, 0, shp_pkg::SUITE_AES128_GCM);
        body_q[0] = 8'h01;
        send_record();
        put_key_share(shp_pkg::GROUP_X25519, shp_pkg::X25519_KEY_LEN, 36);
        build_hello(RND_PLAIN, 0, shp_pkg::SUITE_AES128_GCM);
        rec_type = 8'd23;
        send_record();
        // retry random, both downgrade sentinels, a near sentinel
        put_key_share(shp_pkg::GROUP_X25519, shp_pkg::X25519_KEY_LEN, 36);
        build_hello(RND_RETRY, 0, shp_pkg::SUITE_AES128_GCM);
        send_record();
        put_key_share(shp_pkg::GROUP_X25519, shp_pkg::X25519_KEY_LEN, 36);
        build_hello(RND_DG12, 0, shp_pkg::SUITE_AES128_GCM);
        send_record();
        put_key_share(shp_pkg::GROUP_X25519, shp_pkg::X25519_KEY_LEN, 36);
        build_hello(RND_DG11, 0, shp_pkg::SUITE_AES128_GCM);
        send_record();
        put_key_share(shp_pkg::GROUP_X25519, shp_pkg::X25519_KEY_LEN, 36);
        build_hello(RND_DG_NEAR, 0, shp_pkg::SUITE_AES128_GCM);
        send_record();
        // session id runs past the message
        put_key_share(shp_pkg::GROUP_X25519, shp_pkg::X25519_KEY_LEN, 36);
        build_hello(RND_PLAIN, 0, shp_pkg::SUITE_AES128_GCM);
        body_q[38] = 8'd255;
        send_record();
        // extensions length past the message
        put_key_share(shp_pkg::GROUP_X25519, shp_pkg::X25519_KEY_LEN, 36);
        build_hello(RND_PLAIN, 0, shp_pkg::SUITE_AES128_GCM);
        body_q[42] = 8'd0;
        body_q[43] = 8'(body_q.size() - 44 + 10);
        send_record();
        // extension that does not fit stops the walk before the key share
        put_ext(16'd43, 2);
        ext_q[3] = 8'd200;
        put_key_share(shp_pkg::GROUP_X25519, shp_pkg::X25519_KEY_LEN, 36);
        build_hello(RND_PLAIN, 0, shp_pkg::SUITE_AES128_GCM);
        send_record();
        // short message length, short body, body shorter than the message
        put_key_share(shp_pkg::GROUP_X25519, shp_pkg::X25519_KEY_LEN, 36);
        build_hello(RND_PLAIN, 0, shp_pkg::SUITE_AES128_GCM);
        body_q[1] = 8'd0;
        body_q[2] = 8'd0;
        body_q[3] = 8'd30;
        send_record();
        put_key_share(shp_pkg::GROUP_X25519, shp_pkg::X25519_KEY_LEN, 36);
        build_hello(RND_PLAIN, 0, shp_pkg::SUITE_AES128_GCM);
        while (body_q.size() > 43)
            void'(body_q.pop_back());
        send_record();
        put_key_share(shp_pkg::GROUP_X25519, shp_pkg::X25519_KEY_LEN, 36);
        build_hello(RND_PLAIN, 0, shp_pkg::SUITE_AES128_GCM);
        repeat (5) void'(body_q.pop_back());
        send_record();
        // one-byte record, then an all-ones record
        body_q.delete();
        body_q.push_back(shp_pkg::SERVER_HELLO);
        rec_type = shp_pkg::HANDSHAKE_TYPE;
        send_record();
        body_q.delete();
        repeat (60) body_q.push_back(8'hFF);
        rec_type = 8'hFF;
        send_record();

        // Receiver holds off while short records keep coming
        hold_wanted = 1'b1;
        repeat (12)
        begin
            noise_record(3);
            send_record();
        end

        // Random records, mostly well formed, up to the byte budget
        start_recs = records_sent;
        while (bytes_sent < TOTAL_BYTES || records_sent - start_recs < RANDOM_RECS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                sid = ($urandom_range(0, 4) == 0) ? $urandom_range(33, 255)
                                                  : $urandom_range(0, 32);
                case ($urandom_range(0, 5))
                    0, 1, 2: suite = shp_pkg::SUITE_AES128_GCM;
                    3, 4:    suite = shp_pkg::SUITE_CHACHA20;
                    default: suite = 16'($urandom);
                endcase
                kind = (pick < 65) ? RND_PLAIN
                                   : random_kind_t'($urandom_range(RND_RETRY, RND_DG_NEAR));
                random_extensions();
                build_hello(kind, sid, suite);
                if ($urandom_range(0, 19) == 0)
                    rec_type = 8'($urandom);
                if ($urandom_range(0, 3) == 0)
                    mutate_hello(sid);
            end
            else
            begin
                noise_record(50);
            end
            send_record();
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d records (%0d body bytes); %0d verdicts checked.",
                 records_sent, bytes_sent, verdicts_checked);
        $display("Status codes seen, one bit per code from 0 up: %b", statuses_seen);
        if (fails == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* tls13_server_hello_parser.f */
src/shp_pkg.sv
src/shp_parser.sv
src/tls13_server_hello_parser.sv
bench/shp_hello_checker.sv
bench/tb_top.sv
